@@ sv/hcp_pkg.sv @@
package hcp_pkg;

    // Field and datapath widths
    localparam int TEMP_W   = 16;
    localparam int RAW_W    = 16;
    localparam int TICK_W   = 8;
    localparam int GAIN_W   = 24;
    localparam int ERR_W    = 17;
    localparam int SUM_W    = 32;
    localparam int DELTA_W  = 18;
    localparam int DUTY_W   = 7;
    localparam int REQ_W    = 2;
    localparam int CFG_IDX_W = 3;

    // Product widths: unsigned gain (zero-extended to signed) times signed operand
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
    localparam int PROD_D_W = GAIN_W + 1 + DELTA_W;
    localparam int ACC_W    = PROD_I_W + 1;

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2
    } req_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT    = 3'd0,
        CFG_CYCLE_TIME  = 3'd1,
        CFG_GAIN_P      = 3'd2,
        CFG_GAIN_I      = 3'd3,
        CFG_GAIN_D      = 3'd4,
        CFG_READ_ENABLE = 3'd5
    } cfg_idx_t;

    // Reset values of the configuration registers
    localparam logic [TEMP_W-1:0] SETPOINT_RST   = 16'd370;
    localparam logic [TICK_W-1:0] CYCLE_TIME_RST = 8'd1;

    // Control constants
    localparam logic [TEMP_W-1:0]        TEMP_PID_MIN = 16'd100;
    localparam logic [TEMP_W-1:0]        TARGET_LO    = 16'd368;
    localparam logic [TEMP_W-1:0]        TARGET_HI    = 16'd372;
    localparam logic signed [ERR_W-1:0] ERR_SEP      = 17'sd10;
    localparam logic [DUTY_W-1:0]        DUTY_MAX     = 7'd100;
    localparam logic [DUTY_W-1:0]        DUTY_NEG     = 7'd1;

    typedef struct packed {
        logic [TEMP_W-1:0] setpoint;
        logic [TICK_W-1:0] cycle_time;
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic              read_enable;
    } cfg_t;

    typedef struct packed {
        logic              sample_taken;
        logic [TEMP_W-1:0] temperature;
        logic              at_target;
        logic              duty_valid;
        logic              start_error;
    } flags_t;

    typedef struct packed {
        flags_t                    flags;
        logic                      pid_run;
        logic signed [ERR_W-1:0]   err;
        logic signed [SUM_W-1:0]   err_sum;
        logic signed [DELTA_W-1:0] err_delta;
    } front_t;

    typedef struct packed {
        flags_t                     flags;
        logic                       pid_run;
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
    } prod_t;

    typedef struct packed {
        flags_t            flags;
        logic [DUTY_W-1:0] duty;
    } result_t;

endpackage

@@ sv/hcp_cfg.sv @@
module hcp_cfg import hcp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [GAIN_W-1:0]    wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Write the addressed register; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint    <= SETPOINT_RST;
            cfg_reg.cycle_time  <= CYCLE_TIME_RST;
            cfg_reg.gain_p      <= '0;
            cfg_reg.gain_i      <= '0;
            cfg_reg.gain_d      <= '0;
            cfg_reg.read_enable <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_SETPOINT:    cfg_reg.setpoint    <= wr_data[TEMP_W-1:0];
                CFG_CYCLE_TIME:  cfg_reg.cycle_time  <= wr_data[TICK_W-1:0];
                CFG_GAIN_P:      cfg_reg.gain_p      <= wr_data;
                CFG_GAIN_I:      cfg_reg.gain_i      <= wr_data;
                CFG_GAIN_D:      cfg_reg.gain_d      <= wr_data;
                CFG_READ_ENABLE: cfg_reg.read_enable <= wr_data[0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/hcp_front.sv @@
module hcp_front import hcp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [REQ_W-1:0] req_type,
    input  logic [RAW_W-1:0] raw_sample,
    output logic             out_valid,
    input  logic             out_ready,
    output front_t           out_data
);

    // Input register
    logic             s0_valid_reg;
    logic [REQ_W-1:0] s0_req_reg;
    logic [RAW_W-1:0] s0_raw_reg;

    // Output register
    logic   s1_valid_reg;
    front_t s1_data_reg;

    // Channel state
    logic [TICK_W-1:0]       tick_count_reg, tick_count_next;
    logic signed [SUM_W-1:0] error_sum_reg, error_sum_next;
    logic signed [ERR_W-1:0] prev_error_reg, prev_error_next;
    logic                    heating_reg, heating_next;
    logic [TEMP_W-1:0]       temp_reg, temp_next;

    logic                      s1_ready;
    logic                      s0_fire;
    logic [TICK_W-1:0]         tick_inc;
    logic [RAW_W+3:0]          conv_full;
    logic [TEMP_W-1:0]         temp_conv;
    logic signed [ERR_W-1:0]   err;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic signed [DELTA_W-1:0] delta;
    front_t                    front;

    assign s1_ready = !s1_valid_reg || out_ready;
    assign s0_fire  = s0_valid_reg && s1_ready;
    assign in_ready = !s0_valid_reg || s1_ready;

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= (in_valid && in_ready) || (s0_valid_reg && !s1_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s0_req_reg <= req_type;
            s0_raw_reg <= raw_sample;
        end
    end

    // Convert sixteenths to tenths: raw * 10 >> 4
    assign conv_full = {1'b0, s0_raw_reg, 3'b000} + {3'b000, s0_raw_reg, 1'b0};
    assign temp_conv = conv_full[RAW_W+3:4];

    assign tick_inc = tick_count_reg + TICK_W'(1);
    assign err      = $signed({1'b0, cfg.setpoint}) - $signed({1'b0, temp_conv});
    assign sum_wide = {error_sum_reg[SUM_W-1], error_sum_reg}
                    + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
    assign delta    = {err[ERR_W-1], err} - {prev_error_reg[ERR_W-1], prev_error_reg};

    // Saturate the integral to signed 32 bits
    always_comb
    begin
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                      : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_W-1:0];
        end
    end

    // Decode the request and form the next state
    always_comb
    begin
        tick_count_next = tick_count_reg;
        error_sum_next  = error_sum_reg;
        prev_error_next = prev_error_reg;
        heating_next    = heating_reg;
        temp_next       = temp_reg;
        front           = '0;

        case (s0_req_reg)
            REQ_TICK:
            begin
                if (cfg.read_enable || heating_reg)
                begin
                    if (tick_inc == cfg.cycle_time)
                    begin
                        tick_count_next          = '0;
                        temp_next                = temp_conv;
                        front.flags.sample_taken = 1'b1;
                        if (heating_reg)
                        begin
                            front.flags.duty_valid = 1'b1;
                            if (temp_conv >= TEMP_PID_MIN)
                            begin
                                front.pid_run   = 1'b1;
                                error_sum_next  = (err > ERR_SEP) ? '0 : sum_sat;
                                prev_error_next = err;
                            end
                        end
                    end
                    else
                    begin
                        tick_count_next = tick_inc;
                    end
                end
            end
            REQ_START:
            begin
                if (cfg.setpoint == '0)
                begin
                    front.flags.start_error = 1'b1;
                end
                else
                begin
                    error_sum_next  = '0;
                    prev_error_next = '0;
                    heating_next    = 1'b1;
                end
            end
            REQ_STOP:
            begin
                heating_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        front.flags.temperature = temp_next;
        front.flags.at_target   = (temp_next > TARGET_LO) && (temp_next < TARGET_HI);
        front.err               = err;
        front.err_sum           = error_sum_next;
        front.err_delta         = delta;
    end

    // Advance the channel state once per processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
            heating_reg    <= 1'b0;
            temp_reg       <= '0;
        end
        else if (s0_fire)
        begin
            tick_count_reg <= tick_count_next;
            error_sum_reg  <= error_sum_next;
            prev_error_reg <= prev_error_next;
            heating_reg    <= heating_next;
            temp_reg       <= temp_next;
        end
    end

    // Hold the decoded request for the multiplier stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s0_fire || (s1_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_fire)
        begin
            s1_data_reg <= front;
        end
    end

    assign out_valid = s1_valid_reg;
    assign out_data  = s1_data_reg;

endmodule

@@ sv/hcp_mult.sv @@
module hcp_mult import hcp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output prod_t  out_data
);

    logic  valid_reg;
    prod_t data_reg;
    prod_t prod;
    logic  load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Form the three gain products
    always_comb
    begin
        prod.flags   = in_data.flags;
        prod.pid_run = in_data.pid_run;
        prod.prod_p  = $signed({1'b0, cfg.gain_p}) * in_data.err;
        prod.prod_i  = $signed({1'b0, cfg.gain_i}) * in_data.err_sum;
        prod.prod_d  = $signed({1'b0, cfg.gain_d}) * in_data.err_delta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load || (valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= prod;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ sv/hcp_duty.sv @@
module hcp_duty import hcp_pkg::*;
#(
    parameter int COEF_FRACTION_BITS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  prod_t   in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam logic signed [ACC_W-1:0] DUTY_TOP =
        $signed(ACC_W'(DUTY_MAX) << COEF_FRACTION_BITS);

    // Sum stage
    logic                    a_valid_reg;
    flags_t                  a_flags_reg;
    logic                    a_pid_reg;
    logic signed [ACC_W-1:0] a_acc_reg;

    // Result register
    logic    o_valid_reg;
    result_t o_data_reg;

    logic                    a_ready;
    logic                    a_load;
    logic                    o_load;
    logic signed [ACC_W-1:0] acc_sum;
    logic [DUTY_W-1:0]       duty;
    result_t                 result;

    assign a_ready  = !o_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || a_ready;
    assign a_load   = in_valid && in_ready;
    assign o_load   = a_valid_reg && a_ready;

    // Add the three terms, sign-extended to the accumulator width
    assign acc_sum = {{(ACC_W-PROD_P_W){in_data.prod_p[PROD_P_W-1]}}, in_data.prod_p}
                   + {{(ACC_W-PROD_I_W){in_data.prod_i[PROD_I_W-1]}}, in_data.prod_i}
                   + {{(ACC_W-PROD_D_W){in_data.prod_d[PROD_D_W-1]}}, in_data.prod_d};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_load || (a_valid_reg && !a_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_flags_reg <= in_data.flags;
            a_pid_reg   <= in_data.pid_run;
            a_acc_reg   <= acc_sum;
        end
    end

    // Clamp to the duty range, zero when the PID did not run; drop the fraction bits
    always_comb
    begin
        if (!a_pid_reg)
        begin
            duty = '0;
        end
        else if (a_acc_reg > DUTY_TOP)
        begin
            duty = DUTY_MAX;
        end
        else if (a_acc_reg[ACC_W-1])
        begin
            duty = DUTY_NEG;
        end
        else
        begin
            duty = a_acc_reg[COEF_FRACTION_BITS +: DUTY_W];
        end
        result.flags = a_flags_reg;
        result.duty  = duty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_load || (o_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            o_data_reg <= result;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

@@ sv/heater_pid_channel.sv @@
// One heater control channel: tick counter, sensor conversion and a positional
// PID with integral separation.
// Requests enter on the s_ stream: s_tuser selects tick, start or stop and
// s_tdata carries the raw sensor word. Every request gives exactly one result
// on the m_ stream, in order.
// The user must write registers on the cfg_ channel (always ready) only while the channel
// is idle; the block does not enforce it. cfg_index selects the register, cfg_data the value.
// Pipeline: a request passes the input register, decode and state update,
// gain multipliers, sum and clamp registers, in that order.
// Throughput: one request per cycle unless m_tready stalls the result. The tick
// counter, integral and last error are updated in the single decode stage, so
// each request sees the state left by the one before it; the multipliers and
// clamp follow in separate stages.
// Reset clears the pipeline and channel state (heating off, counters and
// temperature zero) and loads the register defaults.
// When m_tready is low the result holds and the stages fill up behind it;
// s_tready drops only once every stage is occupied.
module heater_pid_channel import hcp_pkg::*;
#(
    parameter int COEF_FRACTION_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_data,
    // Request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] raw_sample
    input  logic [1:0]           s_tuser,   // [1:0] req_type
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [15:0] temperature, [16] at_target, [23:17] duty
    output logic [2:0]           m_tuser    // [0] sample_taken, [1] duty_valid, [2] start_error
);

    cfg_t    cfg;
    logic    front_valid, front_ready;
    front_t  front_data;
    logic    mult_valid, mult_ready;
    prod_t   mult_data;
    result_t result;

    assign cfg_ready = 1'b1;

    hcp_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    hcp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .req_type   (s_tuser),
        .raw_sample (s_tdata),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_data   (front_data)
    );

    hcp_mult u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (mult_valid),
        .out_ready (mult_ready),
        .out_data  (mult_data)
    );

    hcp_duty #(
        .COEF_FRACTION_BITS (COEF_FRACTION_BITS)
    ) u_duty
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mult_valid),
        .in_ready  (mult_ready),
        .in_data   (mult_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result)
    );

    // Pack the result fields
    assign m_tdata = {result.duty, result.flags.at_target, result.flags.temperature};
    assign m_tuser = {result.flags.start_error, result.flags.duty_valid,
                      result.flags.sample_taken};

    // A duty is only computed on a sampling tick
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!result.flags.duty_valid || result.flags.sample_taken))
        else $error("duty reported without a sample");

    // A refused start never samples
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(result.flags.start_error && result.flags.sample_taken))
        else $error("start error on a sampling tick");

    // Duty stays in range and is zero unless newly computed
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((result.duty <= DUTY_MAX)
                      && (result.flags.duty_valid || (result.duty == '0))))
        else $error("duty out of range");

endmodule

@@ test/heater_pid_checker.sv @@
`timescale 1ns / 100ps

// Watch the three channels of one heater channel, track its state and
// compare every result with the one its request predicts.
module heater_pid_checker import hcp_pkg::*;
#(
    parameter int COEF_FRACTION_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] raw_sample
    input  logic [1:0]           s_tuser,   // [1:0] req_type
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [23:0]          m_tdata,   // [15:0] temperature, [16] at_target, [23:17] duty
    input  logic [2:0]           m_tuser,   // [0] sample_taken, [1] duty_valid, [2] start_error
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic              sample_taken;
        logic [TEMP_W-1:0] temperature;
        logic              at_target;
        logic              duty_valid;
        logic [DUTY_W-1:0] duty;
        logic              start_error;
    } channel_result_t;

    localparam longint DUTY_CEILING = longint'(DUTY_MAX) << COEF_FRACTION_BITS;
    localparam longint SUM_MAX      = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_MIN      = -(longint'(1) << (SUM_W - 1));
    localparam int     MAX_REPORTS  = 40;

    // Register copy
    logic [TEMP_W-1:0] setpoint_q  = SETPOINT_RST;
    logic [TICK_W-1:0] cycle_q     = CYCLE_TIME_RST;
    logic [GAIN_W-1:0] kp_q        = '0;
    logic [GAIN_W-1:0] ki_q        = '0;
    logic [GAIN_W-1:0] kd_q        = '0;
    logic              read_en_q   = 1'b0;

    // Channel state copy
    logic [TICK_W-1:0] tick_q      = '0;
    int                integral_q  = 0;
    int                last_err_q  = 0;
    logic              heating_q   = 1'b0;
    logic [TEMP_W-1:0] temp_q      = '0;

    channel_result_t   expected_q[$];
    int                mismatches  = 0;

    // Advance the channel state by one request and return its result
    function automatic channel_result_t predict_response(logic [REQ_W-1:0] kind,
                                                         logic [RAW_W-1:0] raw);
        channel_result_t r;
        longint          err;
        longint          sum;
        longint          acc;
        r = '0;
        case (kind)
            REQ_TICK:
            begin
                if (read_en_q || heating_q)
                begin
                    tick_q = tick_q + 1'b1;
                    if (tick_q == cycle_q)
                    begin
                        tick_q = '0;
                        temp_q = TEMP_W'(({4'd0, raw} * 20'd10) >> 4);
                        r.sample_taken = 1'b1;
                        if (heating_q)
                        begin
                            r.duty_valid = 1'b1;
                            // Too cold for the loop: zero duty, state kept
                            if (temp_q >= TEMP_PID_MIN)
                            begin
                                err = longint'(setpoint_q) - longint'(temp_q);
                                // Integral separation on a large error
                                if (err > longint'(ERR_SEP))
                                begin
                                    integral_q = 0;
                                end
                                else
                                begin
                                    sum = longint'(integral_q) + err;
                                    if (sum > SUM_MAX)
                                        sum = SUM_MAX;
                                    if (sum < SUM_MIN)
                                        sum = SUM_MIN;
                                    integral_q = int'(sum);
                                end
                                acc = longint'(kp_q) * err
                                    + longint'(ki_q) * longint'(integral_q)
                                    + longint'(kd_q) * (err - longint'(last_err_q));
                                last_err_q = int'(err);
                                if (acc > DUTY_CEILING)
                                    r.duty = DUTY_MAX;
                                else if (acc < 0)
                                    r.duty = DUTY_NEG;
                                else
                                    r.duty = DUTY_W'(acc >>> COEF_FRACTION_BITS);
                            end
                        end
                    end
                end
            end
            REQ_START:
            begin
                if (setpoint_q == '0)
                begin
                    r.start_error = 1'b1;
                end
                else
                begin
                    integral_q = 0;
                    last_err_q = 0;
                    heating_q  = 1'b1;
                end
            end
            REQ_STOP:
            begin
                heating_q = 1'b0;
            end
            default:
            begin
            end
        endcase
        r.temperature = temp_q;
        r.at_target   = (temp_q > TARGET_LO) && (temp_q < TARGET_HI);
        return r;
    endfunction

    task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Track registers and requests, check each result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        channel_result_t want;
        channel_result_t got;
        if (!rst_n)
        begin
            setpoint_q = SETPOINT_RST;
            cycle_q    = CYCLE_TIME_RST;
            kp_q       = '0;
            ki_q       = '0;
            kd_q       = '0;
            read_en_q  = 1'b0;
            tick_q     = '0;
            integral_q = 0;
            last_err_q = 0;
            heating_q  = 1'b0;
            temp_q     = '0;
            expected_q.delete();
            pending    <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SETPOINT:    setpoint_q = cfg_data[TEMP_W-1:0];
                    CFG_CYCLE_TIME:  cycle_q    = cfg_data[TICK_W-1:0];
                    CFG_GAIN_P:      kp_q       = cfg_data;
                    CFG_GAIN_I:      ki_q       = cfg_data;
                    CFG_GAIN_D:      kd_q       = cfg_data;
                    CFG_READ_ENABLE: read_en_q  = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with no request pending, tdata %h tuser %h",
                                 $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = expected_q.pop_front();
                    got.temperature  = m_tdata[15:0];
                    got.at_target    = m_tdata[16];
                    got.duty         = m_tdata[23:17];
                    got.sample_taken = m_tuser[0];
                    got.duty_valid   = m_tuser[1];
                    got.start_error  = m_tuser[2];
                    report_field("sample_taken", want.sample_taken, got.sample_taken);
                    report_field("temperature", want.temperature, got.temperature);
                    report_field("at_target", want.at_target, got.at_target);
                    report_field("duty_valid", want.duty_valid, got.duty_valid);
                    report_field("duty", want.duty, got.duty);
                    report_field("start_error", want.start_error, got.start_error);
                end
            end

            if (s_tvalid && s_tready)
                expected_q.push_back(predict_response(s_tuser, s_tdata));

            pending    <= expected_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench import hcp_pkg::*;;

    localparam int               COEF_FRACTION_BITS = 16;
    localparam int               IDLE_PCT           = 19;
    localparam int               HOLD_CYCLES        = 80;
    localparam int               WATCHDOG_LIMIT     = 2000;
    localparam int               PHASES             = 11;
    localparam int               PHASE_ITEMS        = 92;
    localparam int               TEMP_TOP           = 40959;
    localparam logic [REQ_W-1:0] REQ_UNUSED         = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [15:0]          s_tdata;   // [15:0] raw_sample
    logic [1:0]           s_tuser;   // [1:0] req_type
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;   // [15:0] temperature, [16] at_target, [23:17] duty
    logic [2:0]           m_tuser;   // [0] sample_taken, [1] duty_valid, [2] start_error

    int                   fail_count;
    int                   pending;
    int                   stall_cycles = 0;
    logic                 quiet = 1'b0;
    logic                 hold_req = 1'b0;

    always #10 clk = ~clk;

    heater_pid_channel #(
        .COEF_FRACTION_BITS(COEF_FRACTION_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    heater_pid_checker #(
        .COEF_FRACTION_BITS(COEF_FRACTION_BITS)
    ) pid_check (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .fail_count(fail_count),
        .pending(pending)
    );

    // Hold reset from the start, then release it on a clock edge
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Count cycles in which no channel moves anything
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic logic [RAW_W-1:0] raw_for_temp(int tenths);
        return RAW_W'((tenths * 16 + 9) / 10);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return GAIN_W'($urandom_range(24'h040000));
    endfunction

    // Hold one register write until it is taken; valid stays high
    task automatic write_reg(cfg_idx_t idx, logic [GAIN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_regs(int sp, int cyc, logic [GAIN_W-1:0] kp,
                                logic [GAIN_W-1:0] ki, logic [GAIN_W-1:0] kd, int rd);
        write_reg(CFG_SETPOINT, GAIN_W'(sp));
        write_reg(CFG_CYCLE_TIME, GAIN_W'(cyc));
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
        write_reg(CFG_READ_ENABLE, GAIN_W'(rd));
        cfg_valid <= 1'b0;
    endtask

    // Offer one request after a random gap and hold it until taken
    task automatic send_request(logic [REQ_W-1:0] kind, logic [RAW_W-1:0] raw);
        while (!quiet && ($urandom_range(99) < IDLE_PCT))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= raw;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        int               sp;
        int               cyc;
        int               center;
        int               pick;
        int               t;
        logic [REQ_W-1:0] kind;
        logic [RAW_W-1:0] raw;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_TICK;
        cfg_valid = 1'b0;
        cfg_index = CFG_SETPOINT;
        cfg_data  = '0;

        wait (rst_n);
        @(posedge clk);

        // Defaults: idle tick, unused kind, start, one sample with zero gains, stop
        send_request(REQ_TICK, 16'hFFFF);
        send_request(REQ_UNUSED, 16'h5555);
        send_request(REQ_START, 16'h0000);
        send_request(REQ_TICK, raw_for_temp(369));
        send_request(REQ_STOP, 16'hAAAA);
        wait_drained();

        // Zero setpoint refuses start; sample while only reading is enabled
        program_regs(0, 1, 24'h010000, 24'h000800, 24'h004000, 1);
        send_request(REQ_START, 16'h1234);
        send_request(REQ_TICK, 16'h0000);
        send_request(REQ_TICK, 16'hFFFF);
        wait_drained();

        // Heating: cold, far below, at target edges, inside target, far above, restart, stop
        write_reg(CFG_SETPOINT, 24'd370);
        cfg_valid <= 1'b0;
        send_request(REQ_START, 16'h0000);
        send_request(REQ_TICK, raw_for_temp(50));
        send_request(REQ_TICK, raw_for_temp(300));
        send_request(REQ_TICK, raw_for_temp(368));
        send_request(REQ_TICK, raw_for_temp(372));
        send_request(REQ_TICK, raw_for_temp(371));
        send_request(REQ_TICK, 16'hFFFF);
        send_request(REQ_START, 16'hFFFF);
        send_request(REQ_STOP, 16'h0000);
        wait_drained();

        // Counter past a new, smaller cycle time wraps through 255; no idling here
        write_reg(CFG_CYCLE_TIME, 24'd5);
        cfg_valid <= 1'b0;
        quiet = 1'b1;
        repeat (3) send_request(REQ_TICK, RAW_W'($urandom_range(16'hFFFF)));
        wait_drained();
        write_reg(CFG_CYCLE_TIME, 24'd2);
        cfg_valid <= 1'b0;
        send_request(REQ_START, 16'h0000);
        repeat (256) send_request(REQ_TICK, RAW_W'($urandom_range(16'hFFFF)));
        wait_drained();
        quiet = 1'b0;

        // Random phases, each with its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            pick = $urandom_range(7);
            sp = (pick == 0) ? 0 : (pick == 1) ? 65535 : $urandom_range(700, 150);
            pick = $urandom_range(7);
            cyc = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(4, 1);
            program_regs(sp, cyc, pick_gain(), pick_gain(), pick_gain(),
                         $urandom_range(1));
            center = (sp > TEMP_TOP) ? TEMP_TOP : sp;

            // Stall the result side while requests keep coming
            if (phase == 2)
                hold_req = 1'b1;

            if ($urandom_range(9) != 0)
                send_request(REQ_START, RAW_W'($urandom_range(16'hFFFF)));

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                kind = (pick < 3) ? REQ_UNUSED : (pick < 6) ? REQ_STOP :
                       (pick < 10) ? REQ_START : REQ_TICK;
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    // Stay close to the setpoint so the integral builds up
                    t = center + $urandom_range(40) - 20;
                    if (t < 0)
                        t = 0;
                    if (t > TEMP_TOP)
                        t = TEMP_TOP;
                    raw = raw_for_temp(t);
                end
                else if (pick < 90)
                begin
                    raw = RAW_W'($urandom_range(16'hFFFF));
                end
                else
                begin
                    raw = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                end
                send_request(kind, raw);
                if ($urandom_range(199) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
